// ----- hdl/half_plane_intersection_assert.svh -----
// assertion macros for the half-plane intersection checker
// expects signals named clock and reset in the module that uses them
`ifndef HALF_PLANE_INTERSECTION_ASSERT_SVH
`define HALF_PLANE_INTERSECTION_ASSERT_SVH

// same-cycle implication
`define HPI_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("half_plane_intersection: assertion failed");

// next-cycle implication
`define HPI_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("half_plane_intersection: assertion failed");

`endif

// ----- hdl/hpi_pkg.sv -----
// shared types, constants and exact geometry functions for the
// half-plane intersection block; no dependencies
package hpi_pkg;

   localparam int MAX_LINES  = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = $clog2(MAX_LINES);
   localparam int CNT_BITS   = $clog2(MAX_LINES + 1);
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
   localparam int SPLIT_BITS = (CROSS_BITS + 1) / 2;
   localparam int MULT_BITS  = SPLIT_BITS + 1;
   localparam int ACC_BITS   = 2 * CROSS_BITS + 2;

   // deque sizes at which the pop and trim loops run
   localparam int MIN_POP  = 2;
   localparam int MIN_TRIM = 3;

   // direction groups: below the x axis, along +x, upper half and along -x
   localparam logic [1:0] GRP_LOW  = 2'd0;
   localparam logic [1:0] GRP_AXIS = 2'd1;
   localparam logic [1:0] GRP_HIGH = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] sx;
      logic signed [COORD_BITS-1:0] sy;
      logic signed [COORD_BITS-1:0] ex;
      logic signed [COORD_BITS-1:0] ey;
   } line_type;

   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;

   typedef struct packed {
      logic clear;
      logic compare;
      logic insert;
      logic advance;
   } cell_ctl_type;

   typedef struct packed {
      logic done;
      logic result;
   } ins_status_type;

   function automatic diff_type sub(input logic signed [COORD_BITS-1:0] a,
                                    input logic signed [COORD_BITS-1:0] b);
      return DIFF_BITS'(a) - DIFF_BITS'(b);
   endfunction

   function automatic diff_type dir_x(input line_type l);
      return sub(l.ex, l.sx);
   endfunction

   function automatic diff_type dir_y(input line_type l);
      return sub(l.ey, l.sy);
   endfunction

   function automatic cross_type cross2(input diff_type ax, input diff_type ay,
                                        input diff_type bx, input diff_type by);
      logic signed [2*DIFF_BITS-1:0] p;
      logic signed [2*DIFF_BITS-1:0] q;
      p = ax * by;
      q = ay * bx;
      return CROSS_BITS'(p) - CROSS_BITS'(q);
   endfunction

   function automatic logic [1:0] angle_group(input line_type l);
      diff_type dx;
      diff_type dy;
      dx = dir_x(l);
      dy = dir_y(l);
      if (dy < 0) return GRP_LOW;
      if (dy == 0 && dx >= 0) return GRP_AXIS;
      return GRP_HIGH;
   endfunction

   function automatic logic comes_before(input line_type a, input line_type b);
      logic [1:0] ga;
      logic [1:0] gb;
      cross_type c;
      ga = angle_group(a);
      gb = angle_group(b);
      if (ga != gb) return ga < gb;
      c = cross2(dir_x(a), dir_y(a), dir_x(b), dir_y(b));
      if (c != 0) return !c[CROSS_BITS-1];
      // parallel: the one with the other on its right goes first
      c = cross2(dir_x(a), dir_y(a), sub(b.ex, a.sx), sub(b.ey, a.sy));
      return c[CROSS_BITS-1];
   endfunction

   function automatic logic same_angle(input line_type a, input line_type b);
      return angle_group(a) == angle_group(b) &&
             cross2(dir_x(a), dir_y(a), dir_x(b), dir_y(b)) == 0;
   endfunction

endpackage

// ----- hdl/half_plane_intersection.sv -----
// a request enters the sorted cell chain through a compare state, then a shift-in state
// a set closes with last_line; each deque test, pop or trim, runs on the shared
// sequential inside-test unit; each line adds at most two passing tests, each failing one drops a line
// results then follow, each read from the ring memory; busy stays high until the last one is out
// reset (synchronous) clears the control state and the chain valid bits; memory is not cleared
// depends on hpi_pkg, hpi_cell, hpi_inside
module half_plane_intersection (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [hpi_pkg::COORD_BITS-1:0]  req_x_start,
   input  logic signed [hpi_pkg::COORD_BITS-1:0]  req_y_start,
   input  logic signed [hpi_pkg::COORD_BITS-1:0]  req_x_end,
   input  logic signed [hpi_pkg::COORD_BITS-1:0]  req_y_end,
   input  logic                                   req_last_line,
   output logic                                   rsp_valid,
   output logic signed [hpi_pkg::COORD_BITS-1:0]  rsp_out_x_start,
   output logic signed [hpi_pkg::COORD_BITS-1:0]  rsp_out_y_start,
   output logic signed [hpi_pkg::COORD_BITS-1:0]  rsp_out_x_end,
   output logic signed [hpi_pkg::COORD_BITS-1:0]  rsp_out_y_end,
   output logic [hpi_pkg::CNT_BITS-1:0]           rsp_line_count,
   output logic                                   rsp_final_line,
   output logic                                   rsp_overflow
);
   import hpi_pkg::*;

   typedef enum logic [13:0] {
      ST_LOAD  = 14'h0001,
      ST_CMP   = 14'h0002,
      ST_INS   = 14'h0004,
      ST_NEXT  = 14'h0008,
      ST_SAME  = 14'h0010,
      ST_CHECK = 14'h0020,
      ST_FETCH = 14'h0040,
      ST_LATCH = 14'h0080,
      ST_EVAL  = 14'h0100,
      ST_WAIT  = 14'h0200,
      ST_PUSH  = 14'h0400,
      ST_EMIT  = 14'h0800,
      ST_SHOW  = 14'h1000,
      ST_DONE  = 14'h2000
   } hpi_state_type;

   typedef enum logic [1:0] {
      OP_POP_TAIL  = 2'd0,
      OP_POP_HEAD  = 2'd1,
      OP_TRIM_TAIL = 2'd2,
      OP_TRIM_HEAD = 2'd3
   } sweep_op_type;

   hpi_state_type          state_ff;
   sweep_op_type           op_ff;
   logic [CNT_BITS-1:0]    loaded_ff;
   logic                   dropped_ff;
   logic                   last_ff;
   logic                   first_ff;
   logic [IDX_BITS-1:0]    head_ff;
   logic [CNT_BITS-1:0]    size_ff;
   logic [1:0]             slot_ff;
   logic [CNT_BITS-1:0]    emit_ff;
   line_type               new_ff;
   line_type               cur_ff;
   line_type               prev_ff;
   line_type               lines_ff [3];
   line_type               ring [MAX_LINES];
   line_type               rd_data_ff;

   logic                   rsp_valid_ff;
   line_type               rsp_line_ff;
   logic [CNT_BITS-1:0]    rsp_count_ff;
   logic                   rsp_final_ff;
   logic                   rsp_overflow_ff;

   cell_ctl_type           cell_ctl;
   line_type               cell_line [MAX_LINES];
   logic [MAX_LINES-1:0]   cell_valid;
   logic [MAX_LINES-1:0]   cell_before;
   logic [MAX_LINES-1:0]   cell_take;
   logic [MAX_LINES-1:0]   not_before;

   logic                   ins_start;
   ins_status_type         ins_st;

   logic                   accept;
   logic [IDX_BITS-1:0]    slot_addr [3];
   logic [IDX_BITS-1:0]    tail1, tail2, head1;
   logic [IDX_BITS-1:0]    rd_addr;
   logic                   loop_on;
   logic                   op_is_pop;
   sweep_op_type           op_after;
   hpi_state_type          state_after;

   assign accept = start && (state_ff == ST_LOAD);
   assign busy   = (state_ff != ST_LOAD);

   // chain: a new line goes in front of the first cell from which on it precedes all
   assign cell_ctl.clear   = 1'b0;
   assign cell_ctl.compare = (state_ff == ST_CMP);
   assign cell_ctl.insert  = (state_ff == ST_INS);
   assign cell_ctl.advance = (state_ff == ST_NEXT) && (loaded_ff != '0);

   assign not_before = ~cell_before;
   always_comb begin
      for (int j = 0; j < MAX_LINES; j++) begin
         cell_take[j] = ((not_before >> j) == '0);
      end
   end

   for (genvar j = 0; j < MAX_LINES; j++) begin : g_cell
      line_type left_line, right_line;
      logic     left_valid, left_take, right_valid;
      if (j == 0) begin : g_first
         assign left_line  = '0;
         assign left_valid = 1'b0;
         assign left_take  = 1'b0;
      end else begin : g_mid
         assign left_line  = cell_line[j-1];
         assign left_valid = cell_valid[j-1];
         assign left_take  = cell_take[j-1];
      end
      if (j == MAX_LINES - 1) begin : g_last
         assign right_line  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_line  = cell_line[j+1];
         assign right_valid = cell_valid[j+1];
      end
      hpi_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .new_line    (new_ff),
         .left_line   (left_line),
         .left_valid  (left_valid),
         .left_take   (left_take),
         .take        (cell_take[j]),
         .right_line  (right_line),
         .right_valid (right_valid),
         .line        (cell_line[j]),
         .valid       (cell_valid[j]),
         .ahead       (cell_before[j])
      );
   end

   assign ins_start = (state_ff == ST_EVAL);

   hpi_inside u_inside (
      .clock  (clock),
      .reset  (reset),
      .start  (ins_start),
      .l0     (lines_ff[0]),
      .l1     (lines_ff[1]),
      .l2     (lines_ff[2]),
      .status (ins_st)
   );

   // deque addressing
   always_comb begin
      tail1 = IDX_BITS'(CNT_BITS'(head_ff) + size_ff - CNT_BITS'(1));
      tail2 = IDX_BITS'(CNT_BITS'(head_ff) + size_ff - CNT_BITS'(2));
      head1 = head_ff + IDX_BITS'(1);
      op_is_pop = (op_ff == OP_POP_TAIL) || (op_ff == OP_POP_HEAD);
      loop_on   = op_is_pop ? (size_ff >= CNT_BITS'(MIN_POP))
                            : (size_ff >= CNT_BITS'(MIN_TRIM));
      unique case (op_ff)
         OP_POP_TAIL: begin
            slot_addr[0] = head_ff;
            slot_addr[1] = tail2;
            slot_addr[2] = tail1;
         end
         OP_POP_HEAD: begin
            slot_addr[0] = head_ff;
            slot_addr[1] = head_ff;
            slot_addr[2] = head1;
         end
         OP_TRIM_TAIL: begin
            slot_addr[0] = head_ff;
            slot_addr[1] = tail2;
            slot_addr[2] = tail1;
         end
         default: begin
            slot_addr[0] = tail1;
            slot_addr[1] = head_ff;
            slot_addr[2] = head1;
         end
      endcase
      unique case (op_ff)
         OP_POP_TAIL: begin
            op_after    = OP_POP_HEAD;
            state_after = ST_CHECK;
         end
         OP_POP_HEAD: begin
            op_after    = OP_POP_HEAD;
            state_after = ST_PUSH;
         end
         OP_TRIM_TAIL: begin
            op_after    = OP_TRIM_HEAD;
            state_after = ST_CHECK;
         end
         default: begin
            op_after    = OP_TRIM_HEAD;
            state_after = ST_EMIT;
         end
      endcase
      if (state_ff == ST_EMIT) begin
         rd_addr = IDX_BITS'(CNT_BITS'(head_ff) + emit_ff);
      end else begin
         rd_addr = slot_addr[slot_ff];
      end
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_PUSH) begin
         ring[IDX_BITS'(CNT_BITS'(head_ff) + size_ff)] <= cur_ff;
      end
      rd_data_ff <= ring[rd_addr];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         op_ff        <= OP_POP_TAIL;
         loaded_ff    <= '0;
         dropped_ff   <= 1'b0;
         last_ff      <= 1'b0;
         first_ff     <= 1'b1;
         head_ff      <= '0;
         size_ff      <= '0;
         slot_ff      <= 2'd0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  first_ff <= 1'b1;
                  last_ff  <= req_last_line;
                  if (loaded_ff < CNT_BITS'(MAX_LINES)) begin
                     state_ff <= ST_CMP;
                  end else begin
                     dropped_ff <= 1'b1;
                     if (req_last_line) state_ff <= ST_NEXT;
                  end
               end
            end
            ST_CMP: state_ff <= ST_INS;
            ST_INS: begin
               loaded_ff <= loaded_ff + CNT_BITS'(1);
               state_ff  <= last_ff ? ST_NEXT : ST_LOAD;
            end
            ST_NEXT: begin
               if (loaded_ff == '0) begin
                  op_ff    <= OP_TRIM_TAIL;
                  state_ff <= ST_CHECK;
               end else begin
                  loaded_ff <= loaded_ff - CNT_BITS'(1);
                  state_ff  <= ST_SAME;
               end
            end
            ST_SAME: begin
               first_ff <= 1'b0;
               // equal direction as the previous sorted line: drop it
               if (!first_ff && same_angle(cur_ff, prev_ff)) begin
                  state_ff <= ST_NEXT;
               end else begin
                  op_ff    <= OP_POP_TAIL;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (loop_on) begin
                  slot_ff  <= op_is_pop ? 2'd1 : 2'd0;
                  state_ff <= ST_FETCH;
               end else begin
                  op_ff    <= op_after;
                  state_ff <= state_after;
               end
            end
            ST_FETCH: state_ff <= ST_LATCH;
            ST_LATCH: begin
               slot_ff  <= slot_ff + 2'd1;
               state_ff <= (slot_ff == 2'd2) ? ST_EVAL : ST_FETCH;
            end
            ST_EVAL: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (ins_st.done) begin
                  if (!ins_st.result) begin
                     size_ff <= size_ff - CNT_BITS'(1);
                     if (op_ff == OP_POP_HEAD || op_ff == OP_TRIM_HEAD) begin
                        head_ff <= head1;
                     end
                     state_ff <= ST_CHECK;
                  end else begin
                     op_ff    <= op_after;
                     state_ff <= state_after;
                  end
               end
            end
            ST_PUSH: begin
               size_ff  <= size_ff + CNT_BITS'(1);
               state_ff <= ST_NEXT;
            end
            ST_EMIT: state_ff <= ST_SHOW;
            ST_SHOW: begin
               rsp_valid_ff <= 1'b1;
               emit_ff      <= emit_ff + CNT_BITS'(1);
               state_ff     <= (emit_ff + CNT_BITS'(1) == size_ff) ? ST_DONE : ST_EMIT;
            end
            ST_DONE: begin
               head_ff    <= '0;
               size_ff    <= '0;
               emit_ff    <= '0;
               dropped_ff <= 1'b0;
               loaded_ff  <= '0;
               state_ff   <= ST_LOAD;
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         new_ff.sx <= req_x_start;
         new_ff.sy <= req_y_start;
         new_ff.ex <= req_x_end;
         new_ff.ey <= req_y_end;
      end
      if (state_ff == ST_NEXT) begin
         cur_ff <= cell_line[0];
      end
      if (state_ff == ST_SAME) begin
         prev_ff <= cur_ff;
      end
      if (state_ff == ST_CHECK) begin
         lines_ff[0] <= cur_ff;
      end
      if (state_ff == ST_LATCH) begin
         lines_ff[slot_ff] <= rd_data_ff;
      end
      if (state_ff == ST_SHOW) begin
         rsp_line_ff     <= rd_data_ff;
         rsp_count_ff    <= size_ff;
         rsp_final_ff    <= (emit_ff + CNT_BITS'(1) == size_ff);
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x_start = rsp_line_ff.sx;
   assign rsp_out_y_start = rsp_line_ff.sy;
   assign rsp_out_x_end   = rsp_line_ff.ex;
   assign rsp_out_y_end   = rsp_line_ff.ey;
   assign rsp_line_count  = rsp_count_ff;
   assign rsp_final_line  = rsp_final_ff;
   assign rsp_overflow    = rsp_overflow_ff;

endmodule

// ----- hdl/hpi_cell.sv -----
// one cell of the angle-sorted line chain: holds one line and its valid bit
// depends on hpi_pkg
module hpi_cell (
   input  logic                clock,
   input  logic                reset,
   input  hpi_pkg::cell_ctl_type ctl,
   input  hpi_pkg::line_type   new_line,
   input  hpi_pkg::line_type   left_line,
   input  logic                left_valid,
   input  logic                left_take,
   input  logic                take,
   input  hpi_pkg::line_type   right_line,
   input  logic                right_valid,
   output hpi_pkg::line_type   line,
   output logic                valid,
   output logic                ahead
);
   import hpi_pkg::*;

   line_type line_ff;
   logic     valid_ff;
   logic     ahead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.insert && take) begin
         valid_ff <= left_take ? left_valid : 1'b1;
      end else if (ctl.advance) begin
         valid_ff <= right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.insert && take) begin
         line_ff <= left_take ? left_line : new_line;
      end else if (ctl.advance) begin
         line_ff <= right_line;
      end
      // empty cells always let the new line pass in front
      if (ctl.compare) begin
         ahead_ff <= !valid_ff || comes_before(new_line, line_ff);
      end
   end

   assign line  = line_ff;
   assign valid = valid_ff;
   assign ahead = ahead_ff;

endmodule

// ----- hdl/hpi_inside.sv -----
// sequential test: is the intersection of l1 and l2 strictly left of l0
// depends on hpi_pkg; four cross products then four split multiplies
module hpi_inside (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  hpi_pkg::line_type     l0,
   input  hpi_pkg::line_type     l1,
   input  hpi_pkg::line_type     l2,
   output hpi_pkg::ins_status_type status
);
   import hpi_pkg::*;

   typedef enum logic [3:0] {
      IN_IDLE  = 4'b0001,
      IN_CROSS = 4'b0010,
      IN_MULT  = 4'b0100,
      IN_DONE  = 4'b1000
   } ins_state_type;

   ins_state_type state_ff;
   logic [1:0]    phase_ff;
   cross_type     den_ff, a_ff, b_ff, c_ff;
   acc_type       acc_ff;

   cross_type                                 cross_w;
   cross_type                                 mcand;
   cross_type                                 msrc;
   logic signed [CROSS_BITS-SPLIT_BITS-1:0]   hi_part;
   logic signed [MULT_BITS-1:0]               mplier;
   logic signed [CROSS_BITS+MULT_BITS-1:0]    prod;
   acc_type                                   term;
   logic                                      acc_pos, acc_neg;

   always_comb begin
      case (phase_ff)
         2'd0:    cross_w = cross2(dir_x(l1), dir_y(l1), dir_x(l2), dir_y(l2));
         2'd1:    cross_w = cross2(dir_x(l0), dir_y(l0), sub(l1.sx, l0.sx),
                                   sub(l1.sy, l0.sy));
         2'd2:    cross_w = cross2(sub(l2.sx, l1.sx), sub(l2.sy, l1.sy),
                                   dir_x(l2), dir_y(l2));
         default: cross_w = cross2(dir_x(l0), dir_y(l0), dir_x(l1), dir_y(l1));
      endcase
   end

   // a*den + b*c, each multiplier split into a low and a high part
   always_comb begin
      mcand   = phase_ff[1] ? b_ff : a_ff;
      msrc    = phase_ff[1] ? c_ff : den_ff;
      hi_part = msrc[CROSS_BITS-1:SPLIT_BITS];
      if (phase_ff[0]) begin
         mplier = MULT_BITS'(hi_part);
      end else begin
         mplier = signed'({1'b0, msrc[SPLIT_BITS-1:0]});
      end
      prod = mcand * mplier;
      term = ACC_BITS'(prod);
      if (phase_ff[0]) begin
         term = term <<< SPLIT_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IN_IDLE;
         phase_ff <= 2'd0;
      end else begin
         unique case (state_ff)
            IN_IDLE: begin
               if (start) begin
                  state_ff <= IN_CROSS;
                  phase_ff <= 2'd0;
               end
            end
            IN_CROSS: begin
               phase_ff <= phase_ff + 2'd1;
               if (phase_ff == 2'd3) state_ff <= IN_MULT;
            end
            IN_MULT: begin
               phase_ff <= phase_ff + 2'd1;
               if (phase_ff == 2'd3) state_ff <= IN_DONE;
            end
            IN_DONE: state_ff <= IN_IDLE;
            default: state_ff <= IN_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == IN_IDLE) begin
         acc_ff <= '0;
      end
      if (state_ff == IN_CROSS) begin
         case (phase_ff)
            2'd0:    den_ff <= cross_w;
            2'd1:    a_ff   <= cross_w;
            2'd2:    b_ff   <= cross_w;
            default: c_ff   <= cross_w;
         endcase
      end
      if (state_ff == IN_MULT) begin
         acc_ff <= acc_ff + term;
      end
   end

   assign acc_pos = (acc_ff != 0) && !acc_ff[ACC_BITS-1];
   assign acc_neg = acc_ff[ACC_BITS-1];

   // parallel neighbors count as outside
   assign status.done   = (state_ff == IN_DONE);
   assign status.result = (den_ff != 0) && (den_ff[CROSS_BITS-1] ? acc_neg : acc_pos);

endmodule

// ----- hdl/hpi_checker.sv -----
// port-level checks for the half-plane intersection block, bound to the top level
// depends on hpi_pkg and half_plane_intersection_assert.svh
`include "half_plane_intersection_assert.svh"

module hpi_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic [hpi_pkg::CNT_BITS-1:0]           rsp_line_count,
   input logic                                   rsp_final_line
);
   import hpi_pkg::*;

   logic req_taken;
   assign req_taken = start && !busy;

   // results only come while the block holds off new requests
   `HPI_ASSERT_NOW(a_rsp_while_busy, rsp_valid, busy)
   // an answer never reports zero surviving lines
   `HPI_ASSERT_NOW(a_rsp_count_nonzero, rsp_valid, rsp_line_count != '0)
   // no response line directly follows the final line of an answer
   `HPI_ASSERT_NEXT(a_final_ends_answer, rsp_valid && rsp_final_line, !rsp_valid)
   // a request just taken cannot produce a result in the next cycle
   `HPI_ASSERT_NEXT(a_no_rsp_after_req, req_taken, !rsp_valid)

endmodule

bind half_plane_intersection hpi_checker u_hpi_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_line_count (rsp_line_count),
   .rsp_final_line (rsp_final_line)
);

// ----- tb/sv/half_plane_intersection_tb.sv -----
// testbench for half_plane_intersection: sends line sets, predicts the surviving boundary
// lines with exact wide integer geometry and checks every response field
// depends on hpi_pkg and half_plane_intersection
`timescale 1ns / 1ps

module half_plane_intersection_tb;
   import hpi_pkg::*;

   typedef logic signed [127:0] wide_t;

   typedef struct {
      line_type l;
      int       count;
      bit       fin;
      bit       ovf;
   } boundary_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [COORD_BITS-1:0] req_x_start, req_y_start, req_x_end, req_y_end;
   logic req_last_line;
   logic rsp_valid;
   logic signed [COORD_BITS-1:0] rsp_out_x_start, rsp_out_y_start;
   logic signed [COORD_BITS-1:0] rsp_out_x_end, rsp_out_y_end;
   logic [CNT_BITS-1:0] rsp_line_count;
   logic rsp_final_line;
   logic rsp_overflow;

   line_type     pending_set[$];
   bit           set_dropped;
   boundary_type expected_boundary[$];
   int idle_pct;
   int errors;
   int sets_closed;
   int lines_sent;
   int lines_checked;

   half_plane_intersection i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_start(req_x_start), .req_y_start(req_y_start),
      .req_x_end(req_x_end), .req_y_end(req_y_end), .req_last_line(req_last_line),
      .rsp_valid(rsp_valid), .rsp_out_x_start(rsp_out_x_start),
      .rsp_out_y_start(rsp_out_y_start), .rsp_out_x_end(rsp_out_x_end),
      .rsp_out_y_end(rsp_out_y_end), .rsp_line_count(rsp_line_count),
      .rsp_final_line(rsp_final_line), .rsp_overflow(rsp_overflow)
   );

   always begin
      clock = 1'b0; #2;
      clock = 1'b1; #2;
   end

   // exact geometry on wide signed words
   function automatic wide_t xprod(wide_t ax, wide_t ay, wide_t bx, wide_t by);
      return ax * by - ay * bx;
   endfunction

   function automatic wide_t ddx(line_type l);
      return wide_t'(l.ex) - wide_t'(l.sx);
   endfunction

   function automatic wide_t ddy(line_type l);
      return wide_t'(l.ey) - wide_t'(l.sy);
   endfunction

   function automatic logic [1:0] heading_group(line_type l);
      if (ddy(l) < 0) return GRP_LOW;
      if (ddy(l) == 0 && ddx(l) >= 0) return GRP_AXIS;
      return GRP_HIGH;
   endfunction

   function automatic bit precedes(line_type a, line_type b);
      wide_t c;
      if (heading_group(a) != heading_group(b)) return heading_group(a) < heading_group(b);
      c = xprod(ddx(a), ddy(a), ddx(b), ddy(b));
      if (c != 0) return c > 0;
      // same direction: tighter line first
      c = xprod(ddx(a), ddy(a), wide_t'(b.ex) - wide_t'(a.sx), wide_t'(b.ey) - wide_t'(a.sy));
      return c < 0;
   endfunction

   function automatic bit parallel_same(line_type a, line_type b);
      return heading_group(a) == heading_group(b) &&
             xprod(ddx(a), ddy(a), ddx(b), ddy(b)) == 0;
   endfunction

   // meeting point of l1 and l2 strictly left of l0
   function automatic bit meets_inside(line_type l0, line_type l1, line_type l2);
      wide_t den, a, b, c, v;
      den = xprod(ddx(l1), ddy(l1), ddx(l2), ddy(l2));
      if (den == 0) return 0;
      a = xprod(ddx(l0), ddy(l0), wide_t'(l1.sx) - wide_t'(l0.sx),
                wide_t'(l1.sy) - wide_t'(l0.sy));
      b = xprod(wide_t'(l2.sx) - wide_t'(l1.sx), wide_t'(l2.sy) - wide_t'(l1.sy),
                ddx(l2), ddy(l2));
      c = xprod(ddx(l0), ddy(l0), ddx(l1), ddy(l1));
      v = a * den + b * c;
      if (den < 0) v = -v;
      return v > 0;
   endfunction

   task automatic predict_boundary();
      int order[$];
      int dq[$];
      int pos;
      int n;
      boundary_type r;
      n = pending_set.size();
      for (int k = 0; k < n; k++) begin
         pos = order.size();
         order = {order, k};
         while (pos > 0 && precedes(pending_set[k], pending_set[order[pos-1]])) begin
            order[pos] = order[pos-1];
            pos--;
         end
         order[pos] = k;
      end
      for (int i = 0; i < n; i++) begin
         if (i > 0 && parallel_same(pending_set[order[i]], pending_set[order[i-1]])) continue;
         while (dq.size() >= MIN_POP && !meets_inside(pending_set[order[i]],
                pending_set[dq[dq.size()-2]], pending_set[dq[dq.size()-1]]))
            dq.delete(dq.size() - 1);
         while (dq.size() >= MIN_POP && !meets_inside(pending_set[order[i]],
                pending_set[dq[0]], pending_set[dq[1]]))
            dq.delete(0);
         dq = {dq, order[i]};
      end
      while (dq.size() >= MIN_TRIM && !meets_inside(pending_set[dq[0]],
             pending_set[dq[dq.size()-2]], pending_set[dq[dq.size()-1]]))
         dq.delete(dq.size() - 1);
      while (dq.size() >= MIN_TRIM && !meets_inside(pending_set[dq[dq.size()-1]],
             pending_set[dq[0]], pending_set[dq[1]]))
         dq.delete(0);
      foreach (dq[k]) begin
         r.l     = pending_set[dq[k]];
         r.count = dq.size();
         r.fin   = (k == dq.size() - 1);
         r.ovf   = set_dropped;
         expected_boundary = {expected_boundary, r};
      end
      pending_set.delete();
      set_dropped = 0;
      sets_closed++;
   endtask

   // one request; start stays high if the next request follows at once
   task automatic send_line(line_type l, bit last);
      int gap;
      req_x_start   <= l.sx;
      req_y_start   <= l.sy;
      req_x_end     <= l.ex;
      req_y_end     <= l.ey;
      req_last_line <= last;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      lines_sent++;
      if (pending_set.size() < MAX_LINES) pending_set = {pending_set, l};
      else set_dropped = 1;
      if (last) predict_boundary();
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic line_type mk(int sx, int sy, int ex, int ey);
      line_type l;
      l.sx = COORD_BITS'(sx); l.sy = COORD_BITS'(sy);
      l.ex = COORD_BITS'(ex); l.ey = COORD_BITS'(ey);
      return l;
   endfunction

   // random line with the origin on its kept side, so sets close into a region
   function automatic line_type around_origin(int span);
      line_type l;
      wide_t c;
      l = mk($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
             $urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span);
      c = xprod(ddx(l), ddy(l), -wide_t'(l.sx), -wide_t'(l.sy));
      if (c < 0) l = mk(l.ex, l.ey, l.sx, l.sy);
      return l;
   endfunction

   function automatic line_type wild_line();
      return mk($urandom, $urandom, $urandom, $urandom);
   endfunction

   always @(posedge clock) begin
      boundary_type e;
      if (!reset && rsp_valid) begin
         lines_checked++;
         if (expected_boundary.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response line %0d %0d %0d %0d",
               rsp_out_x_start, rsp_out_y_start, rsp_out_x_end, rsp_out_y_end);
         end else begin
            e = expected_boundary[0];
            expected_boundary.delete(0);
            if (rsp_out_x_start !== e.l.sx || rsp_out_y_start !== e.l.sy ||
                rsp_out_x_end !== e.l.ex || rsp_out_y_end !== e.l.ey ||
                rsp_line_count !== CNT_BITS'(e.count) || rsp_final_line !== e.fin ||
                rsp_overflow !== e.ovf) begin
               errors++;
               if (errors <= 10)
                  $display("exp %0d %0d %0d %0d cnt %0d fin %0b ovf %0b / %s",
                     e.l.sx, e.l.sy, e.l.ex, e.l.ey, e.count, e.fin, e.ovf,
                     $sformatf("got %0d %0d %0d %0d cnt %0d fin %0b ovf %0b",
                        rsp_out_x_start, rsp_out_y_start, rsp_out_x_end, rsp_out_y_end,
                        rsp_line_count, rsp_final_line, rsp_overflow));
            end
         end
      end
   end

   task automatic test_shapes();
      // triangle, square, extreme corners
      send_line(mk(0, 0, 10, 0), 0);
      send_line(mk(10, 0, 0, 10), 0);
      send_line(mk(0, 10, 0, 0), 1);
      send_line(mk(-5, -5, 5, -5), 0);
      send_line(mk(5, -5, 5, 5), 0);
      send_line(mk(5, 5, -5, 5), 0);
      send_line(mk(-5, 5, -5, -5), 1);
      send_line(mk(-32768, -32768, 32767, -32768), 0);
      send_line(mk(32767, -32768, 32767, 32767), 0);
      send_line(mk(32767, 32767, -32768, 32767), 0);
      send_line(mk(-32768, 32767, -32768, -32768), 1);
   endtask

   task automatic test_special_lines();
      // single line
      send_line(mk(1, 2, 3, 4), 1);
      // zero-length line, equal directions, collinear tie, opposite parallels
      send_line(mk(7, 7, 7, 7), 0);
      send_line(mk(0, 0, 4, 0), 0);
      send_line(mk(0, 2, 4, 2), 0);
      send_line(mk(8, 0, 9, 0), 0);
      send_line(mk(4, 9, 0, 9), 0);
      send_line(mk(3, 3, 3, 3), 1);
      send_line(mk(0, 0, 1, 1), 0);
      send_line(mk(2, 2, 0, 0), 1);
      // boundary point exactly on a line
      send_line(mk(0, 0, 2, 0), 0);
      send_line(mk(2, 0, 0, 2), 0);
      send_line(mk(0, 2, 0, 0), 0);
      send_line(mk(-1, 1, 1, -1), 1);
   endtask

   task automatic test_capacity();
      for (int i = 0; i < MAX_LINES + 3; i++)
         send_line(around_origin(1000), i == MAX_LINES + 2);
      // next set right after overflow must start clean
      send_line(around_origin(50), 0);
      send_line(around_origin(50), 0);
      send_line(around_origin(50), 1);
   endtask

   task automatic test_random_sets(int pct, int n_items);
      int sent;
      int size;
      int span;
      idle_pct = pct;
      sent = 0;
      while (sent < n_items) begin
         size = $urandom_range(1, 8);
         span = ($urandom_range(1) == 0) ? 8 : 30000;
         for (int i = 0; i < size; i++) begin
            if ($urandom_range(9) < 7) send_line(around_origin(span), i == size - 1);
            else send_line(wild_line(), i == size - 1);
         end
         sent += size;
      end
   endtask

   task automatic test_drain_pause();
      start <= 1'b0;
      wait (expected_boundary.size() == 0);
      repeat (40) @(posedge clock);
      send_line(around_origin(20), 0);
      send_line(around_origin(20), 1);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_x_start = '0; req_y_start = '0; req_x_end = '0; req_y_end = '0;
      req_last_line = 1'b0;
      idle_pct = 0;
      errors = 0; sets_closed = 0; lines_sent = 0; lines_checked = 0;
      set_dropped = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_shapes();
      test_special_lines();
      test_random_sets(0, 15);
      test_random_sets(61, 15);
      test_drain_pause();
      test_random_sets(21, 15);
      test_capacity();
      test_random_sets(0, 15);
      start <= 1'b0;
      wait (expected_boundary.size() == 0);
      repeat (200) @(posedge clock);
      $display("%0d lines in %0d sets sent, %0d boundary lines checked, overflow set included",
               lines_sent, sets_closed, lines_checked);
      if (errors == 0 && expected_boundary.size() == 0)
         $display("half_plane_intersection: match");
      else
         $display("half_plane_intersection: mismatch");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("half_plane_intersection: mismatch");
      $finish;
   end

endmodule
